>>> design/keyframe_value_interpolator_core_macros.svh
// ----------------------------------------------------------------------------
// keyframe value interpolator assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VALUE_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_VALUE_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define KVI_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kvi assertion failed");
`define KVI_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kvi assertion failed");
`else
`define KVI_ASSERT(name, prop)
`define KVI_ASSERT_IMP(name, ante, cons)
`endif
`endif

>>> design/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// types and codes of the keyframe value interpolator
// ----------------------------------------------------------------------------
package kvi_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_FALLBACK = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_RND,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [23:0] key_frame;
    logic signed [31:0] key_value;
    logic               use_bezier;
    logic signed [31:0] control_out;
    logic signed [31:0] control_in;
    logic signed [23:0] query_frame;
    logic signed [31:0] fallback_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    status_e            status;
  } rsp_t;

  typedef struct packed {
    logic signed [23:0] frame;
    logic signed [31:0] value;
    logic               easing;
    logic signed [31:0] ctrl_out;
    logic signed [31:0] ctrl_in;
  } key_t;

  typedef struct packed {
    logic ins;
    logic valid;
    logic at_end;
  } cell_ctl_t;

  localparam int DivSteps = 16;
  localparam int MulSteps = 10;

endpackage

>>> design/keyframe_value_interpolator_core.sv
// ----------------------------------------------------------------------------
// keyframe_value_interpolator_core
// sorted keyframe track with linear and cubic bezier interpolation
// ----------------------------------------------------------------------------
// requests enter on in_valid_i/in_stall_o with an in_req_i payload, one
// response per request leaves on out_valid_o/out_stall_i as out_rsp_o.
// the table is a row of MAX_KEYS cells; an insert shifts larger frames one
// cell to the right in the accept cycle, clear just zeroes the fill count.
// clear, insert, no-op, empty and clamped queries and queries that land
// exactly on a key frame go from idle straight to the done state, which
// loads the output register as soon as it is free. an interpolated query
// runs the t divider, one quotient bit per cycle for the 16-bit t, then
// the multiply state: one step for linear, or ten steps of the shared
// multiplier for bezier, then a rounding state before the done state.
// one request is in flight at a time, so a new one is not taken before the
// last response is loaded; in_stall_o is high while it is busy.
// a finished response waits in its own stage while the output register is
// stalled, so the block holds at most one response plus the one on the port.
// reset empties the table and drops any request in flight; table contents
// are not cleared, only the fill count.
// ----------------------------------------------------------------------------
`include "keyframe_value_interpolator_core_macros.svh"

module keyframe_value_interpolator_core #(
  parameter int MAX_KEYS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  kvi_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output kvi_pkg::rsp_t  out_rsp_o
);

  localparam int CW = $clog2(MAX_KEYS + 1);

  kvi_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q;
  logic            accept;
  logic            full;
  logic            do_ins;

  kvi_pkg::key_t   new_key;
  kvi_pkg::key_t   entries  [MAX_KEYS];
  kvi_pkg::key_t   left_ent [MAX_KEYS];
  logic [MAX_KEYS-1:0] gt, ge, seg;
  kvi_pkg::key_t   lsel, rsel, last;

  // datapath registers
  logic [23:0]        span_q, rem_q, dnum;
  logic [15:0]        t_q;
  logic [3:0]         cnt_q;
  logic               phase_q;
  logic               ease_q;
  logic signed [31:0] lv_q, rv_q, co_q, ci_q;
  logic [32:0]        u2_q;
  logic [31:0]        t2_q;
  logic [24:0]        w_q [4];
  logic signed [61:0] acc_q;
  logic signed [60:0] prod_q;
  logic signed [31:0] res_val_q;
  kvi_pkg::status_e   res_st_q;
  logic               out_valid_q;
  kvi_pkg::rsp_t      out_q;

  logic [16:0]        u;
  logic signed [34:0] ma;
  logic signed [25:0] mb;
  logic [24:0]        div_sh;
  logic signed [32:0] ldiff;
  logic [51:0]        wraw, wrnd;
  logic signed [61:0] rnd, shv;
  logic               div_last, mul_last, out_load;
  logic signed [24:0] qd, qs;

  assign accept  = in_valid_i && !in_stall_o;
  assign full    = (count_q == CW'(MAX_KEYS));
  assign do_ins  = accept && (in_req_i.op == kvi_pkg::OP_INSERT) && !full;
  assign new_key = '{frame:    in_req_i.key_frame,
                     value:    in_req_i.key_value,
                     easing:   in_req_i.use_bezier,
                     ctrl_out: in_req_i.control_out,
                     ctrl_in:  in_req_i.control_in};

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    kvi_pkg::cell_ctl_t ctl;
    logic lgt, lge;
    if (i == 0) begin : g_first
      assign left_ent[i] = '0;
      assign lgt = 1'b0;
      assign lge = 1'b0;
    end else begin : g_rest
      assign left_ent[i] = entries[i-1];
      assign lgt = gt[i-1];
      assign lge = ge[i-1];
    end
    assign ctl = '{ins:    do_ins,
                   valid:  (CW'(i) < count_q),
                   at_end: (CW'(i) == count_q)};
    kvi_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .key_i     (new_key),
      .qframe_i  (in_req_i.query_frame),
      .left_i    (left_ent[i]),
      .left_gt_i (lgt),
      .left_ge_i (lge),
      .entry_o   (entries[i]),
      .gt_o      (gt[i]),
      .ge_o      (ge[i]),
      .seg_o     (seg[i])
    );
  end

  always_comb begin
    lsel = '0;
    rsel = '0;
    last = '0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (seg[i]) begin
        lsel = left_ent[i];
        rsel = entries[i];
      end
      if (count_q == CW'(i + 1)) begin
        last = entries[i];
      end
    end
  end

  assign qd   = 25'(in_req_i.query_frame) - 25'(lsel.frame);
  assign qs   = 25'(rsel.frame) - 25'(lsel.frame);
  assign dnum = qd[23:0];

  // divider and multiplier operands
  assign div_sh   = {rem_q, 1'b0};
  assign div_last = (cnt_q == 4'(kvi_pkg::DivSteps - 1));
  assign mul_last = phase_q && (!ease_q || cnt_q == 4'(kvi_pkg::MulSteps - 1));
  assign u        = 17'd65536 - {1'b0, t_q};
  assign ldiff    = 33'(rv_q) - 33'(lv_q);

  always_comb begin
    ma = '0;
    mb = '0;
    if (!ease_q) begin
      ma = 35'(ldiff);
      mb = {10'b0, t_q};
    end else begin
      case (cnt_q)
        4'd0:    begin ma = {18'b0, u};   mb = {9'b0, u};   end
        4'd1:    begin ma = {19'b0, t_q}; mb = {10'b0, t_q}; end
        4'd2:    begin ma = {2'b0, u2_q}; mb = {9'b0, u};   end
        4'd3:    begin ma = {2'b0, u2_q}; mb = {10'b0, t_q}; end
        4'd4:    begin ma = {3'b0, t2_q}; mb = {9'b0, u};   end
        4'd5:    begin ma = {3'b0, t2_q}; mb = {10'b0, t_q}; end
        4'd6:    begin ma = 35'(lv_q);    mb = {1'b0, w_q[0]}; end
        4'd7:    begin ma = 35'(co_q);    mb = {1'b0, w_q[1]}; end
        4'd8:    begin ma = 35'(ci_q);    mb = {1'b0, w_q[2]}; end
        4'd9:    begin ma = 35'(rv_q);    mb = {1'b0, w_q[3]}; end
        default: begin ma = '0;           mb = '0;           end
      endcase
    end
  end

  always_comb begin
    if (cnt_q == 4'd3 || cnt_q == 4'd4) begin
      wraw = {prod_q[50:0], 1'b0} + 52'(prod_q[50:0]);
    end else begin
      wraw = 52'(prod_q[50:0]);
    end
    wrnd = wraw + 52'd8388608;
  end

  assign rnd = acc_q + (ease_q ? 62'sd8388608 : 62'sd32768);
  assign shv = ease_q ? (rnd >>> 24) : (rnd >>> 16);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kvi_pkg::S_IDLE: begin
        if (accept) begin
          state_d = kvi_pkg::S_DONE;
          if (in_req_i.op == kvi_pkg::OP_QUERY && count_q != '0 &&
              in_req_i.query_frame > entries[0].frame &&
              in_req_i.query_frame < last.frame &&
              in_req_i.query_frame != rsel.frame) begin
            state_d = kvi_pkg::S_DIV;
          end
        end
      end
      kvi_pkg::S_DIV:  if (div_last) state_d = kvi_pkg::S_MUL;
      kvi_pkg::S_MUL:  if (mul_last) state_d = kvi_pkg::S_RND;
      kvi_pkg::S_RND:  state_d = kvi_pkg::S_DONE;
      kvi_pkg::S_DONE: if (out_load) state_d = kvi_pkg::S_IDLE;
      default:         state_d = kvi_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o = (state_q != kvi_pkg::S_IDLE);
    out_load   = (state_q == kvi_pkg::S_DONE) && (!out_valid_q || !out_stall_i);
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvi_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && in_req_i.op == kvi_pkg::OP_CLEAR) begin
        count_q <= '0;
      end else if (do_ins) begin
        count_q <= count_q + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= '{value_out: res_val_q, status: res_st_q};
    end
    case (state_q)
      kvi_pkg::S_IDLE: begin
        cnt_q   <= '0;
        phase_q <= 1'b0;
        acc_q   <= '0;
        t_q     <= '0;
        rem_q   <= dnum;
        span_q  <= qs[23:0];
        ease_q  <= lsel.easing;
        lv_q    <= lsel.value;
        co_q    <= lsel.ctrl_out;
        rv_q    <= rsel.value;
        ci_q    <= rsel.ctrl_in;
        res_val_q <= '0;
        res_st_q  <= kvi_pkg::ST_OK;
        if (in_req_i.op == kvi_pkg::OP_INSERT && full) begin
          res_st_q <= kvi_pkg::ST_FULL;
        end else if (in_req_i.op == kvi_pkg::OP_QUERY) begin
          if (count_q == '0) begin
            res_val_q <= in_req_i.fallback_value;
            res_st_q  <= kvi_pkg::ST_FALLBACK;
          end else if (in_req_i.query_frame <= entries[0].frame) begin
            res_val_q <= entries[0].value;
          end else if (in_req_i.query_frame < last.frame) begin
            res_val_q <= rsel.value;
          end else begin
            res_val_q <= last.value;
          end
        end
      end
      kvi_pkg::S_DIV: begin
        if (div_sh >= {1'b0, span_q}) begin
          rem_q <= 24'(div_sh - {1'b0, span_q});
          t_q   <= {t_q[14:0], 1'b1};
        end else begin
          rem_q <= div_sh[23:0];
          t_q   <= {t_q[14:0], 1'b0};
        end
        cnt_q <= div_last ? '0 : cnt_q + 4'd1;
      end
      kvi_pkg::S_MUL: begin
        phase_q <= !phase_q;
        if (!phase_q) begin
          prod_q <= ma * mb;
        end else if (!ease_q) begin
          acc_q <= (62'(lv_q) <<< 16) + 62'(prod_q);
        end else begin
          cnt_q <= cnt_q + 4'd1;
          case (cnt_q)
            4'd0:    u2_q   <= prod_q[32:0];
            4'd1:    t2_q   <= prod_q[31:0];
            4'd2:    w_q[0] <= wrnd[48:24];
            4'd3:    w_q[1] <= wrnd[48:24];
            4'd4:    w_q[2] <= wrnd[48:24];
            4'd5:    w_q[3] <= wrnd[48:24];
            default: acc_q  <= acc_q + 62'(prod_q);
          endcase
        end
      end
      kvi_pkg::S_RND: begin
        if (shv > 62'sd2147483647) begin
          res_val_q <= 32'sh7fffffff;
          res_st_q  <= kvi_pkg::ST_SAT;
        end else if (shv < -62'sd2147483648) begin
          res_val_q <= 32'sh80000000;
          res_st_q  <= kvi_pkg::ST_SAT;
        end else begin
          res_val_q <= shv[31:0];
          res_st_q  <= kvi_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  `KVI_ASSERT(a_count_bound, count_q <= CW'(MAX_KEYS))
  `KVI_ASSERT(a_ins_count, do_ins |=> (count_q == $past(count_q) + CW'(1)))
  `KVI_ASSERT_IMP(a_out_from_done, $rose(out_valid_o), $past(state_q == kvi_pkg::S_DONE))
  `KVI_ASSERT_IMP(a_div_rem, state_q == kvi_pkg::S_DIV, rem_q < span_q)

endmodule

>>> design/kvi_cell.sv
// ----------------------------------------------------------------------------
// kvi_cell
// one keyframe slot of the sorted table, shifts right on insert
// ----------------------------------------------------------------------------
module kvi_cell (
  input  logic                clk_i,
  input  kvi_pkg::cell_ctl_t  ctl_i,
  input  kvi_pkg::key_t       key_i,
  input  logic signed [23:0]  qframe_i,
  input  kvi_pkg::key_t       left_i,
  input  logic                left_gt_i,
  input  logic                left_ge_i,
  output kvi_pkg::key_t       entry_o,
  output logic                gt_o,
  output logic                ge_o,
  output logic                seg_o
);

  kvi_pkg::key_t entry_q, entry_d;

  assign gt_o    = ctl_i.valid && (entry_q.frame > key_i.frame);
  assign ge_o    = ctl_i.valid && (entry_q.frame >= qframe_i);
  assign seg_o   = ge_o && !left_ge_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        entry_d = left_i;
      end else if (gt_o || ctl_i.at_end) begin
        entry_d = key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> tb/tb_keyframe_value_interpolator_core.sv
// ----------------------------------------------------------------------------
// keyframe value interpolator core testbench
// drives clear, insert, query and no-op requests through the valid/stall ports and
// checks every response against a behavioral model of the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keyframe_value_interpolator_core;

  localparam int NumKeys = 16;
  localparam int WatchdogLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  kvi_pkg::req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  kvi_pkg::rsp_t out_rsp_o;

  keyframe_value_interpolator_core #(.MAX_KEYS(NumKeys)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .in_req_i(in_req_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_rsp_o(out_rsp_o)
  );

  kvi_pkg::key_t track_keys[NumKeys];
  int unsigned track_len;
  kvi_pkg::rsp_t expected_rsps[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned idle_cycles;
  int unsigned query_count;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint round_shift(longint x, int s);
    longint y;
    y = x + (longint'(1) << (s - 1));
    return y >>> s;
  endfunction

  function automatic kvi_pkg::rsp_t interp_track(kvi_pkg::req_t r);
    kvi_pkg::rsp_t res;
    kvi_pkg::key_t nk;
    longint fr, lf, span, v, acc, lv, diff;
    longint unsigned t, u, w0, w1, w2, w3;
    int pos;
    bit found;
    res.value_out = '0;
    res.status = kvi_pkg::ST_OK;
    case (r.op)
      kvi_pkg::OP_CLEAR: track_len = 0;
      kvi_pkg::OP_INSERT: begin
        if (track_len >= NumKeys) begin
          res.status = kvi_pkg::ST_FULL;
        end else begin
          nk = '{r.key_frame, r.key_value, r.use_bezier, r.control_out, r.control_in};
          pos = track_len;
          while (pos > 0 && track_keys[pos - 1].frame > r.key_frame) begin
            track_keys[pos] = track_keys[pos - 1];
            pos--;
          end
          track_keys[pos] = nk;
          track_len++;
        end
      end
      kvi_pkg::OP_QUERY: begin
        fr = r.query_frame;
        found = 1'b0;
        if (track_len == 0) begin
          res.value_out = r.fallback_value;
          res.status = kvi_pkg::ST_FALLBACK;
        end else if (fr <= track_keys[0].frame) begin
          res.value_out = track_keys[0].value;
        end else if (fr >= track_keys[track_len - 1].frame) begin
          res.value_out = track_keys[track_len - 1].value;
        end else begin
          for (int i = 1; i < track_len && !found; i++) begin
            lf = track_keys[i - 1].frame;
            span = longint'(track_keys[i].frame) - lf;
            if (fr <= track_keys[i].frame && span > 0) begin
              found = 1'b1;
              t = longint'((fr - lf) * 65536) / span;
              if (t > 65536) t = 65536;
              if (track_keys[i - 1].easing) begin
                u = 65536 - t;
                w0 = (u * u * u + (64'd1 << 23)) >> 24;
                w1 = (3 * u * u * t + (64'd1 << 23)) >> 24;
                w2 = (3 * u * t * t + (64'd1 << 23)) >> 24;
                w3 = (t * t * t + (64'd1 << 23)) >> 24;
                acc = longint'(track_keys[i - 1].value) * longint'(w0)
                    + longint'(track_keys[i - 1].ctrl_out) * longint'(w1)
                    + longint'(track_keys[i].ctrl_in) * longint'(w2)
                    + longint'(track_keys[i].value) * longint'(w3);
                v = round_shift(acc, 24);
              end else begin
                lv = track_keys[i - 1].value;
                diff = longint'(track_keys[i].value) - lv;
                acc = lv * 65536 + diff * longint'(t);
                v = round_shift(acc, 16);
              end
              if (v > 64'sd2147483647) begin
                res.value_out = 32'sh7fffffff;
                res.status = kvi_pkg::ST_SAT;
              end else if (v < -64'sd2147483648) begin
                res.value_out = 32'sh80000000;
                res.status = kvi_pkg::ST_SAT;
              end else begin
                res.value_out = v[31:0];
              end
            end
          end
          if (!found) begin
            res.value_out = r.fallback_value;
            res.status = kvi_pkg::ST_FALLBACK;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(kvi_pkg::req_t r);
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_req_i <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (r.op == kvi_pkg::OP_QUERY) query_count++;
    expected_rsps.insert(expected_rsps.size(), interp_track(r));
    sent_count++;
  endtask

  function automatic kvi_pkg::req_t rand_req(kvi_pkg::op_e op);
    kvi_pkg::req_t r;
    r.op = op;
    r.key_frame = 24'($urandom);
    r.key_value = $urandom;
    r.use_bezier = 1'($urandom);
    r.control_out = $urandom;
    r.control_in = $urandom;
    r.query_frame = 24'($urandom);
    r.fallback_value = $urandom;
    return r;
  endfunction

  task automatic insert_key(int f, int v, bit bz, int co, int ci);
    kvi_pkg::req_t r;
    r = rand_req(kvi_pkg::OP_INSERT);
    r.key_frame = 24'(f);
    r.key_value = v;
    r.use_bezier = bz;
    r.control_out = co;
    r.control_in = ci;
    send_request(r);
  endtask

  task automatic query_at(int f);
    kvi_pkg::req_t r;
    r = rand_req(kvi_pkg::OP_QUERY);
    r.query_frame = 24'(f);
    send_request(r);
  endtask

  task automatic test_directed();
    kvi_pkg::req_t r;
    send_request(rand_req(kvi_pkg::OP_CLEAR));
    query_at(0);
    insert_key(10, 32'sh00010000, 1'b0, 0, 0);
    insert_key(-8388608, 32'sh80000000, 1'b1, 32'sh7fffffff, 32'sh7fffffff);
    insert_key(8388607, 32'sh7fffffff, 1'b0, 32'sh80000000, 32'sh80000000);
    insert_key(10, 32'sh00050000, 1'b1, 32'sh7fffffff, 32'sh80000000);
    insert_key(20, -32'sh00030000, 1'b0, 0, 0);
    query_at(-8388608);
    query_at(8388607);
    query_at(10);
    query_at(15);
    query_at(20);
    query_at(-1000);
    query_at(4000000);
    r = rand_req(kvi_pkg::OP_NONE);
    send_request(r);
    for (int i = 0; i < 12; i++) insert_key(100 + i, $urandom, 1'b1, $urandom, $urandom);
    query_at(105);
    send_request(rand_req(kvi_pkg::OP_CLEAR));
    query_at(5);
  endtask

  task automatic test_random(int unsigned n);
    kvi_pkg::req_t r;
    int base;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(19))
        0: send_request(rand_req(kvi_pkg::OP_CLEAR));
        1: send_request(rand_req(kvi_pkg::OP_NONE));
        2, 3, 4, 5, 6: begin
          r = rand_req(kvi_pkg::OP_INSERT);
          if ($urandom_range(3) != 0) r.key_frame = 24'($signed($urandom_range(200)) - 100);
          if ($urandom_range(1)) begin
            r.key_value = $signed($urandom_range(65536 * 200)) - 65536 * 100;
            r.control_out = $signed($urandom_range(65536 * 400)) - 65536 * 200;
            r.control_in = $signed($urandom_range(65536 * 400)) - 65536 * 200;
          end
          send_request(r);
        end
        default: begin
          r = rand_req(kvi_pkg::OP_QUERY);
          if ($urandom_range(4) != 0) begin
            base = $urandom_range(220);
            r.query_frame = 24'(base - 110);
          end
          send_request(r);
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_pct != 0) out_stall_i <= ($urandom_range(99) < stall_pct);
    else out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    kvi_pkg::rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response value=%h status=%0d", $time,
                 out_rsp_o.value_out, out_rsp_o.status);
        error_count++;
      end else begin
        want = expected_rsps.pop_front();
        checked_count++;
        if (out_rsp_o.value_out !== want.value_out) begin
          $display("%0t: value mismatch expected %h actual %h", $time,
                   want.value_out, out_rsp_o.value_out);
          error_count++;
        end
        if (out_rsp_o.status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want.status, out_rsp_o.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_valid_i = 1'b0;
    in_req_i = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    track_len = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(400);
    send_idle_pct = 82;
    test_random(400);
    send_idle_pct = 0;
    stall_pct = 82;
    test_random(400);
    send_idle_pct = 9;
    stall_pct = 9;
    test_random(400);
    stall_pct = 0;
    send_idle_pct = 0;
    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("sent %0d requests (%0d queries), checked %0d responses", sent_count,
             query_count, checked_count);
    $display("idle and stall mixes covered: none, sender, receiver, both");
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
